// ===== rtl/mhol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhol_pkg
// Shared types and constants of the min-heap open list.
// ----------------------------------------------------------------------------
package mhol_pkg;

	localparam int HEAP_DEPTH_DEF = 256;
	localparam int COORD_BITS_DEF = 10;
	localparam int COST_W = 32;
	localparam int TAG_W = 16;
	localparam int XY_W = COORD_BITS_DEF;
	localparam int COUNT_W = 9;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP = 1'b1;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DECREASED = 3'd1,
		ST_IGNORED   = 3'd2,
		ST_POPPED    = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		logic              opcode;
		logic [XY_W-1:0]   cell_x;
		logic [XY_W-1:0]   cell_y;
		logic [COST_W-1:0] path_cost;
		logic [COST_W-1:0] priority_cost;
		logic [TAG_W-1:0]  tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [XY_W-1:0]    out_x;
		logic [XY_W-1:0]    out_y;
		logic [COST_W-1:0]  out_path_cost;
		logic [COST_W-1:0]  out_priority;
		logic [TAG_W-1:0]   out_tag;
		logic [COUNT_W-1:0] entry_count;
	} out_item_t;

endpackage

// ===== rtl/mhol_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhol_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mhol_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// read before write, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/min_heap_open_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_open_list
// Binary min-heap open list with push-or-decrease by coordinate and pop-min.
// ----------------------------------------------------------------------------
// channel | direction | payload    | handshake
// in      | input     | in_item_t  | in_valid / in_stall
// out     | output    | out_item_t | out_valid / out_stall
//
// One transaction at a time through a single-port entry memory.
// Push: linear coordinate scan of the live entries, then sift-up level by
// level. Pop: root and last entry are read, then sift-down level by level.
// The worst case is a push scanning a nearly full heap.
// Reset clears the count and control; entries need no clearing.
// A result waits in the output register; the next transaction is taken only
// after it leaves.
// ----------------------------------------------------------------------------
module min_heap_open_list
	import mhol_pkg::*;
#(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);
	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int EW = 2 * COST_W + 2 * COORD_BITS + TAG_W;

	typedef struct packed {
		logic [COST_W-1:0]     key;
		logic [COST_W-1:0]     g;
		logic [2*COORD_BITS-1:0] coord;
		logic [TAG_W-1:0]      tag;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CK, S_UP_RD, S_UP_CK, S_UP_WR, S_UP_SWAP,
		S_POP_RD, S_POP_LAST, S_POP_WAIT, S_DN_RD, S_DN_L, S_DN_R, S_DN_CK,
		S_DN_WR, S_DN_SWAP, S_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      best_q;
	entry_t             cur_q;
	entry_t             other_q;
	entry_t             best_e_q;
	in_item_t           req_q;
	out_item_t          res_q;
	logic               out_valid_q;

	logic               we;
	logic [AW-1:0]      addr;
	entry_t             wdata;
	logic [EW-1:0]      rdata_raw;
	entry_t             rdata;
	entry_t             new_e;
	logic [AW+1:0]      lchild;
	logic [AW+1:0]      rchild;

	assign rdata = entry_t'(rdata_raw);
	assign new_e = '{key: req_q.priority_cost, g: req_q.path_cost,
		coord: {req_q.cell_y[COORD_BITS-1:0], req_q.cell_x[COORD_BITS-1:0]},
		tag: req_q.tag};
	assign lchild = {1'b0, pos_q, 1'b1};
	assign rchild = lchild + (AW+2)'(1);

	mhol_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata_raw)
	);

	// memory port control
	always_comb begin
		we = 1'b0;
		addr = pos_q;
		wdata = cur_q;
		case (state_q)
			S_SCAN_RD:  addr = idx_q[AW-1:0];
			S_UP_RD:    addr = (pos_q - AW'(1)) >> 1;
			S_UP_WR, S_UP_SWAP: begin
				we = 1'b1;
				addr = pos_q;
				wdata = cur_q;
			end
			S_POP_RD:   addr = '0;
			S_POP_LAST: addr = idx_q[AW-1:0];
			S_DN_RD:    addr = lchild[AW-1:0];
			S_DN_L:     addr = rchild[AW-1:0];
			S_DN_WR, S_DN_SWAP: begin
				we = 1'b1;
				addr = pos_q;
				wdata = cur_q;
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = res_q;

	// sequencer, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			pos_q <= '0;
			best_q <= '0;
			cur_q <= '0;
			other_q <= '0;
			best_e_q <= '0;
			req_q <= '0;
			res_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						req_q <= in_data;
						idx_q <= '0;
						if (in_data.opcode == OP_POP) begin
							if (count_q == '0) begin
								res_q <= '{status: ST_EMPTY, default: '0};
								state_q <= S_DONE;
							end else begin
								res_q <= '0;
								state_q <= S_POP_RD;
							end
						end else begin
							res_q <= '0;
							state_q <= S_SCAN_RD;
						end
					end
				end
				// linear scan of live entries for the coordinate
				S_SCAN_RD: begin
					if (idx_q == count_q) begin
						if (count_q == CW'(HEAP_DEPTH)) begin
							res_q.status <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							res_q.status <= ST_INSERTED;
							cur_q <= new_e;
							pos_q <= idx_q[AW-1:0];
							count_q <= count_q + CW'(1);
							state_q <= S_UP_WR;
						end
					end else begin
						state_q <= S_SCAN_CK;
					end
				end
				S_SCAN_CK: begin
					if (rdata.coord == new_e.coord) begin
						if (new_e.g < rdata.g) begin
							res_q.status <= ST_DECREASED;
							cur_q <= new_e;
							pos_q <= idx_q[AW-1:0];
							state_q <= S_UP_WR;
						end else begin
							res_q.status <= ST_IGNORED;
							state_q <= S_DONE;
						end
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				// sift up: write current, read parent, compare
				S_UP_WR: begin
					state_q <= (pos_q == '0) ? S_DONE : S_UP_RD;
				end
				S_UP_RD: begin
					state_q <= S_UP_CK;
				end
				S_UP_CK: begin
					if (rdata.key > cur_q.key) begin
						// move parent down, continue at parent slot
						cur_q <= rdata;
						other_q <= cur_q;
						pos_q <= pos_q;
						state_q <= S_UP_SWAP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_UP_SWAP: begin
					cur_q <= other_q;
					pos_q <= (pos_q - AW'(1)) >> 1;
					state_q <= S_UP_WR;
				end
				// pop: read root, then last entry
				S_POP_RD: begin
					idx_q <= count_q - CW'(1);
					state_q <= S_POP_LAST;
				end
				S_POP_LAST: begin
					res_q <= '{status: ST_POPPED,
						out_x: XY_W'(rdata.coord[COORD_BITS-1:0]),
						out_y: XY_W'(rdata.coord[2*COORD_BITS-1:COORD_BITS]),
						out_path_cost: rdata.g,
						out_priority: rdata.key,
						out_tag: rdata.tag,
						entry_count: '0};
					count_q <= count_q - CW'(1);
					pos_q <= '0;
					state_q <= S_POP_WAIT;
				end
				S_POP_WAIT: begin
					cur_q <= rdata;
					state_q <= S_DN_WR;
				end
				// sift down: write current, read children, compare
				S_DN_WR: begin
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					best_q <= pos_q;
					best_e_q <= cur_q;
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					if (lchild < (AW+2)'(count_q) && rdata.key < cur_q.key) begin
						best_q <= lchild[AW-1:0];
						best_e_q <= rdata;
					end
					state_q <= S_DN_R;
				end
				S_DN_R: begin
					if (rchild < (AW+2)'(count_q) && rdata.key < best_e_q.key) begin
						best_q <= rchild[AW-1:0];
						best_e_q <= rdata;
					end
					state_q <= S_DN_CK;
				end
				S_DN_CK: begin
					if (best_q == pos_q) begin
						state_q <= S_DONE;
					end else begin
						// child moves up into this slot
						other_q <= cur_q;
						cur_q <= best_e_q;
						state_q <= S_DN_SWAP;
					end
				end
				S_DN_SWAP: begin
					cur_q <= other_q;
					pos_q <= best_q;
					state_q <= S_DN_WR;
				end
				S_DONE: begin
					res_q.entry_count <= COUNT_W'(count_q);
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
